@@ hdl/positional_list_engine_unit_assert.svh @@
// Assertion macros for the file that carries checks, the top-level unit.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checks that cons holds in the same cycle as ante.
`define PLE_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional list engine check failed");
// Checks that cons holds in the cycle after ante.
`define PLE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional list engine check failed");
`else
`define PLE_ASSERT_NOW(name, clk, rst, ante, cons)
`define PLE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

@@ hdl/ple_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package ple_pkg;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 5;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_FRONT = 3'd0,
      CMD_ADD_BACK  = 3'd1,
      CMD_ADD_AT    = 3'd2,
      CMD_REM_FRONT = 3'd3,
      CMD_REM_BACK  = 3'd4,
      CMD_REM_AT    = 3'd5,
      CMD_DUMP      = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DUMP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic dump_step;
   } ctl_type;

   typedef struct packed {
      logic is_dump;
      logic empty;
      logic dump_last;
   } sts_type;

endpackage
`default_nettype wire

@@ hdl/positional_list_engine_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit entries held in a row of
// registers, front at cell 0. Inserts and removals shift the cells at and
// behind the given position in parallel. A command that is not a dump is
// first accepted and then executed, which loads the output register. A
// dump of n entries is accepted and executed likewise and then sends one
// entry per cycle while rsp_ready does not stall, since the row rotates
// by one cell per result and the front cell feeds the output register.
// Only one item is in work at a time; the next item can be accepted
// while the last result still waits in the output register.
// Status codes: 0 ok, 1 invalid position, 2 list empty, 3 list full.
`include "positional_list_engine_unit_assert.svh"
module positional_list_engine_unit #(
   parameter int CAPACITY = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic        [ple_pkg::CMD_W-1:0]   req_cmd,
   input  wire logic signed [ple_pkg::VALUE_W-1:0] req_value,
   input  wire logic        [ple_pkg::POS_W-1:0]   req_position,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic        [ple_pkg::STATUS_W-1:0]     rsp_status,
   output logic signed [ple_pkg::VALUE_W-1:0]      rsp_entry,
   output logic        [ple_pkg::COUNT_W-1:0]      rsp_count,
   output logic                                    rsp_is_last
);
   import ple_pkg::*;

   localparam int OCC_W = $clog2(CAPACITY + 1);

   ctl_type          ctl;
   sts_type          sts;
   logic [OCC_W-1:0] occ_level;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   ple_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_cmd      (req_cmd),
      .req_value    (req_value),
      .req_position (req_position),
      .ctl          (ctl),
      .sts          (sts),
      .occ_level    (occ_level),
      .rsp_status   (rsp_status),
      .rsp_entry    (rsp_entry),
      .rsp_count    (rsp_count),
      .rsp_is_last  (rsp_is_last)
   );

   `PLE_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_level <= OCC_W'(CAPACITY))
   `PLE_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready)
   `PLE_ASSERT_NEXT(a_occ_moves_on_exec, clock, reset, !ctl.execute, $stable(occ_level))
   `PLE_ASSERT_NOW(a_error_is_single, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_is_last && rsp_entry == '0)

endmodule
`default_nettype wire

@@ hdl/ple_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ple_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire ple_pkg::sts_type sts,
   output ple_pkg::ctl_type      ctl
);
   import ple_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;
   logic      rsp_load;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               state_in = (sts.is_dump && !sts.empty) ? S_DUMP : S_IDLE;
            end
         end
         S_DUMP: begin
            if (slot_free && sts.dump_last) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      rsp_load  = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            ctl.capture = req_valid;
         end
         S_EXEC: begin
            ctl.execute = slot_free;
            rsp_load    = slot_free && !(sts.is_dump && !sts.empty);
         end
         S_DUMP: begin
            ctl.dump_step = slot_free;
            rsp_load      = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ hdl/ple_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module ple_datapath #(
   parameter int CAPACITY = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic        [ple_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic signed [ple_pkg::VALUE_W-1:0]   req_value,
   input  wire logic        [ple_pkg::POS_W-1:0]     req_position,
   input  wire ple_pkg::ctl_type                     ctl,
   output ple_pkg::sts_type                          sts,
   output logic        [$clog2(CAPACITY+1)-1:0]      occ_level,
   output logic        [ple_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [ple_pkg::VALUE_W-1:0]        rsp_entry,
   output logic        [ple_pkg::COUNT_W-1:0]        rsp_count,
   output logic                                      rsp_is_last
);
   import ple_pkg::*;

   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((OCC_W > POS_W) ? OCC_W : POS_W) + 1;

   logic [CMD_W-1:0]   cmd_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [POS_W-1:0]   pos_ff;

   logic [VALUE_W-1:0] cells_ff [CAPACITY];
   logic [VALUE_W-1:0] cells_in [CAPACITY];
   logic [VALUE_W-1:0] up_nb    [CAPACITY];
   logic [VALUE_W-1:0] dn_nb    [CAPACITY];

   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;
   logic [OCC_W-1:0] remain_ff;
   logic [OCC_W-1:0] remain_in;

   logic [STATUS_W-1:0] status_ff;
   logic [VALUE_W-1:0]  entry_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                is_last_ff;
   logic [STATUS_W-1:0] status_in;
   logic [VALUE_W-1:0]  entry_in;
   logic [COUNT_W-1:0]  count_in;
   logic                is_last_in;

   logic [CMP_W-1:0] occ_x;
   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] idx;
   logic [CMP_W-1:0] occ_next_x;
   status_type       op_status;
   logic             do_ins;
   logic             do_rem;
   logic             empty;
   logic             full;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_nb
         if (g == CAPACITY - 1) begin : g_top
            assign up_nb[g] = cells_ff[g];
         end else begin : g_mid
            assign up_nb[g] = cells_ff[g + 1];
         end
         if (g == 0) begin : g_bot
            assign dn_nb[g] = cells_ff[g];
         end else begin : g_low
            assign dn_nb[g] = cells_ff[g - 1];
         end
      end
   endgenerate

   assign occ_x = CMP_W'(occ_ff);
   assign pos_x = CMP_W'(pos_ff);
   assign empty = (occ_ff == '0);
   assign full  = (occ_ff == OCC_W'(CAPACITY));

   always_comb begin
      op_status = ST_OK;
      do_ins    = 1'b0;
      do_rem    = 1'b0;
      idx       = '0;
      unique case (cmd_type'(cmd_ff))
         CMD_ADD_FRONT, CMD_ADD_BACK: begin
            if (full) begin
               op_status = ST_FULL;
            end else begin
               do_ins = 1'b1;
               idx    = (cmd_type'(cmd_ff) == CMD_ADD_FRONT) ? '0 : occ_x;
            end
         end
         CMD_ADD_AT: begin
            if (pos_x == '0 || pos_x > occ_x + CMP_W'(1)) begin
               op_status = ST_BADPOS;
            end else if (full) begin
               op_status = ST_FULL;
            end else begin
               do_ins = 1'b1;
               idx    = pos_x - CMP_W'(1);
            end
         end
         CMD_REM_FRONT, CMD_REM_BACK: begin
            if (empty) begin
               op_status = ST_EMPTY;
            end else begin
               do_rem = 1'b1;
               idx    = (cmd_type'(cmd_ff) == CMD_REM_FRONT) ? '0 : occ_x - CMP_W'(1);
            end
         end
         CMD_REM_AT: begin
            if (pos_x == '0 || pos_x > occ_x) begin
               op_status = ST_BADPOS;
            end else begin
               do_rem = 1'b1;
               idx    = pos_x - CMP_W'(1);
            end
         end
         CMD_DUMP: begin
            op_status = empty ? ST_EMPTY : ST_OK;
         end
         default: begin
            op_status = ST_OK;
         end
      endcase
   end

   always_comb begin
      occ_next_x = occ_x;
      if (do_ins) begin
         occ_next_x = occ_x + CMP_W'(1);
      end else if (do_rem) begin
         occ_next_x = occ_x - CMP_W'(1);
      end
   end

   // A dump step rotates the occupied cells by one toward the front, so
   // the front cell is always the next one to send and the list is back
   // in order after the last step.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (ctl.execute && do_ins) begin
            if (CMP_W'(i) == idx) begin
               cells_in[i] = value_ff;
            end else if (CMP_W'(i) > idx) begin
               cells_in[i] = dn_nb[i];
            end
         end else if (ctl.execute && do_rem) begin
            if (CMP_W'(i) >= idx) begin
               cells_in[i] = up_nb[i];
            end
         end else if (ctl.dump_step) begin
            if (CMP_W'(i) + CMP_W'(1) < occ_x) begin
               cells_in[i] = up_nb[i];
            end else if (CMP_W'(i) + CMP_W'(1) == occ_x) begin
               cells_in[i] = cells_ff[0];
            end
         end
      end
   end

   always_comb begin
      occ_in     = occ_ff;
      remain_in  = remain_ff;
      status_in  = status_ff;
      entry_in   = entry_ff;
      count_in   = count_ff;
      is_last_in = is_last_ff;
      if (ctl.execute) begin
         occ_in = OCC_W'(occ_next_x);
         if (sts.is_dump && !empty) begin
            remain_in = occ_ff;
         end else begin
            status_in  = op_status;
            entry_in   = '0;
            count_in   = COUNT_W'(occ_next_x);
            is_last_in = 1'b1;
         end
      end else if (ctl.dump_step) begin
         remain_in  = remain_ff - OCC_W'(1);
         status_in  = ST_OK;
         entry_in   = cells_ff[0];
         count_in   = COUNT_W'(occ_x);
         is_last_in = sts.dump_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff    <= '0;
         remain_ff <= '0;
      end else begin
         occ_ff    <= occ_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff   <= req_cmd;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      cells_ff   <= cells_in;
      status_ff  <= status_in;
      entry_ff   <= entry_in;
      count_ff   <= count_in;
      is_last_ff <= is_last_in;
   end

   assign sts.is_dump   = (cmd_ff == CMD_DUMP);
   assign sts.empty     = empty;
   assign sts.dump_last = (remain_ff == OCC_W'(1));

   assign occ_level   = occ_ff;
   assign rsp_status  = status_ff;
   assign rsp_entry   = entry_ff;
   assign rsp_count   = count_ff;
   assign rsp_is_last = is_last_ff;

endmodule
`default_nettype wire
